/* hdl/npcs_pkg.sv */
// Shared constants of the prime counter sieve: field widths and default sizes.
package npcs_pkg;

  // Fixed payload widths of the request and response channels
  localparam int INDEX_W = 8;
  localparam int OUT_W   = 16;

  // Default table depth and value width
  localparam int DEF_MAX_PRIMES = 256;
  localparam int DEF_VALUE_BITS = 16;

  // The search always starts from this prime
  localparam int unsigned FIRST_PRIME = 2;

endpackage

/* hdl/npcs_if.sv */
// Valid/ready stream interfaces for the request and response channels.
interface npcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [npcs_pkg::INDEX_W-1:0] prime_index;

  modport source (output valid, output prime_index, input ready);
  modport sink   (input valid, input prime_index, output ready);
endinterface

interface npcs_out_if;
  logic                       valid;
  logic                       ready;
  logic [npcs_pkg::OUT_W-1:0] prime_value;

  modport source (output valid, output prime_value, input ready);
  modport sink   (input valid, input prime_value, output ready);
endinterface

/* hdl/nth_prime_counter_sieve_unit.sv */
// Top level of the prime counter sieve: sequencer, residue table and step unit.
//
// Usage: a request on req carries prime_index (0 selects 2); indices at or
// above MAX_PRIMES saturate to MAX_PRIMES-1. The response on rsp carries
// prime_value, the requested prime (low 16 bits). Both channels move a
// request when valid and ready are high at a rising edge of clk.
// Each request restarts the search from 2. For every candidate the sequencer
// sweeps the residue table once through the single shared residue unit, one
// entry per cycle through the table's one read and one write port. Index 0
// answers without a search; index 255 returns prime 1619. If the candidate
// reaches 2^VALUE_BITS-1 first, the largest prime found is returned. One
// request is worked on at a time; req.ready is high only while idle. The
// response sits in an output register, so a new request is taken while an
// earlier response waits; a finished search holds until that register frees
// up. rst is synchronous and returns the block to idle with no response
// pending; the table needs no clearing after reset.
module nth_prime_counter_sieve_unit #(
  parameter int MAX_PRIMES = npcs_pkg::DEF_MAX_PRIMES,
  parameter int VALUE_BITS = npcs_pkg::DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  npcs_in_if.sink     req,
  npcs_out_if.source  rsp
);

  localparam int ADDR_W  = $clog2(MAX_PRIMES);
  localparam int CNT_W   = $clog2(MAX_PRIMES + 1);
  localparam int ENTRY_W = 2 * VALUE_BITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NEXT   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]            state;
  logic [ADDR_W-1:0]     want;
  logic [CNT_W-1:0]      count;
  logic [VALUE_BITS-1:0] candidate;
  logic [VALUE_BITS-1:0] last_prime;
  logic [CNT_W-1:0]      issue_idx;
  logic                  s1_valid;
  logic [ADDR_W-1:0]     s1_idx;
  logic                  s1_last;
  logic                  wrapped;
  logic                  out_valid;
  logic [npcs_pkg::OUT_W-1:0] out_value;

  logic                  req_fire;
  logic                  issue;
  logic                  append;
  logic                  load_out;
  logic [ADDR_W-1:0]     want_sat;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W-1:0]      issue_inc;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic [ENTRY_W-1:0]    rd_data;
  logic [VALUE_BITS-1:0] rd_prime;
  logic [VALUE_BITS-1:0] rd_residue;
  logic [VALUE_BITS-1:0] residue_upd;
  logic                  step_wrap;
  logic [VALUE_BITS-1:0] first_prime;
  logic                  cand_full;

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.prime_value = out_value;

  assign rd_prime    = rd_data[ENTRY_W-1:VALUE_BITS];
  assign rd_residue  = rd_data[VALUE_BITS-1:0];
  assign first_prime = VALUE_BITS'(npcs_pkg::FIRST_PRIME);
  assign cand_full   = (candidate == {VALUE_BITS{1'b1}});

  // Control decode
  always_comb begin
    req_fire  = req.valid && (state == ST_IDLE);
    issue     = (state == ST_SCAN) && (issue_idx != count);
    append    = (state == ST_DECIDE) && !wrapped && (count < CNT_W'(MAX_PRIMES));
    load_out  = (state == ST_RESULT) && (!out_valid || rsp.ready);
    count_inc = count + CNT_W'(1);
    issue_inc = issue_idx + CNT_W'(1);
    if (32'(req.prime_index) > 32'(MAX_PRIMES - 1)) begin
      want_sat = ADDR_W'(MAX_PRIMES - 1);
    end else begin
      want_sat = ADDR_W'(req.prime_index);
    end
  end

  // Table write port: restart entry, residue write-back or new prime
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {first_prime, {VALUE_BITS{1'b0}}};
    priority if (req_fire) begin
      wr_en = 1'b1;
    end else if (s1_valid) begin
      wr_en   = 1'b1;
      wr_addr = s1_idx;
      wr_data = {rd_prime, residue_upd};
    end else if (append) begin
      wr_en   = 1'b1;
      wr_addr = count[ADDR_W-1:0];
      wr_data = {candidate, {VALUE_BITS{1'b0}}};
    end else begin
      wr_en = 1'b0;
    end
  end

  npcs_table #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (issue_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  npcs_residue_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .prime       (rd_prime),
    .residue     (rd_residue),
    .residue_upd (residue_upd),
    .wrap        (step_wrap)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= CNT_W'(1);
      candidate  <= first_prime;
      last_prime <= first_prime;
      issue_idx  <= '0;
      s1_valid   <= 1'b0;
      s1_last    <= 1'b0;
      wrapped    <= 1'b0;
      want       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            want       <= want_sat;
            count      <= CNT_W'(1);
            candidate  <= first_prime;
            last_prime <= first_prime;
            state      <= (want_sat == '0) ? ST_RESULT : ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (cand_full) begin
            state <= ST_RESULT;
          end else begin
            candidate <= candidate + VALUE_BITS'(1);
            issue_idx <= '0;
            wrapped   <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue is already low when the last entry is in the read stage
          s1_valid <= issue;
          if (issue) begin
            issue_idx <= issue_inc;
            s1_last   <= (issue_inc == count);
          end
          if (s1_valid) begin
            wrapped <= wrapped | step_wrap;
            if (s1_last) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (append) begin
            count      <= count_inc;
            last_prime <= candidate;
            state      <= (count_inc > CNT_W'(want)) ? ST_RESULT : ST_NEXT;
          end else begin
            state <= ST_NEXT;
          end
        end
        ST_RESULT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Index of the entry in the read stage
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx <= issue_idx[ADDR_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= npcs_pkg::OUT_W'(last_prime);
    end
  end

  // Checks
  a_stage_in_scan : assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (state == ST_SCAN))
    else $error("read stage active outside the table sweep");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNT_W'(MAX_PRIMES)))
    else $error("prime count out of range");

  a_issue_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_idx <= count))
    else $error("sweep index ran past the table fill");

  a_restart : assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (count == CNT_W'(1)) && (last_prime == first_prime))
    else $error("search did not restart on a new request");

  a_load_out : assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && (state == ST_IDLE))
    else $error("finished search not handed to the output register");

endmodule

/* hdl/npcs_table.sv */
// Single-port-write, single-port-read table of {prime, residue} entries.
module npcs_table #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/npcs_residue_unit.sv */
// Shared residue step: advance one counter and wrap it at its prime.
module npcs_residue_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic [VALUE_BITS-1:0] prime,
  input  logic [VALUE_BITS-1:0] residue,
  output logic [VALUE_BITS-1:0] residue_upd,
  output logic                  wrap
);

  logic [VALUE_BITS-1:0] incr;

  // Increment modulo 2^VALUE_BITS, then fold back to zero at the prime
  always_comb begin
    incr        = residue + VALUE_BITS'(1);
    wrap        = (incr == prime);
    residue_upd = wrap ? '0 : incr;
  end

endmodule
